// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the indexed array store.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define IAIDS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is held.
`define IAIDS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/iaids_pkg.sv =====
// Package for the indexed array store: command, status, cell and FSM codes.
// Depends on nothing; used by the interfaces, the cell and the top level.
`default_nettype none

package iaids_pkg;

  // Field widths fixed by the transaction format
  localparam int CMD_W    = 2;
  localparam int POS_W    = 5;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int FPOS_W   = 4;
  localparam int FILL_W   = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT  = 2'd0,
    CMD_DELETE  = 2'd1,
    CMD_SEARCH  = 2'd2,
    CMD_DISPLAY = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK       = 3'd0,
    STS_FULL     = 3'd1,
    STS_BADPOS   = 3'd2,
    STS_NOTFOUND = 3'd3,
    STS_EMPTY    = 3'd4
  } status_t;

  // Operation broadcast to every cell of the chain
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_ROTATE = 2'd3
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_SEARCH  = 2'd1,
    ST_DISPLAY = 2'd2
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/iaids_if.sv =====
// Valid/ready channel interfaces for command and result transactions.
// Depends on iaids_pkg for field widths.
`default_nettype none

interface iaids_in_if;
  logic                             valid;
  logic                             ready;
  logic [iaids_pkg::CMD_W-1:0]      command;
  logic [iaids_pkg::POS_W-1:0]      position;
  logic signed [iaids_pkg::VALUE_W-1:0] value;

  modport source (output valid, command, position, value, input ready);
  modport sink   (input valid, command, position, value, output ready);
endinterface

interface iaids_out_if;
  logic                             valid;
  logic                             ready;
  logic [iaids_pkg::STATUS_W-1:0]   status;
  logic [iaids_pkg::FPOS_W-1:0]     found_position;
  logic signed [iaids_pkg::VALUE_W-1:0] data;
  logic [iaids_pkg::FILL_W-1:0]     fill_count;
  logic                             last;

  modport source (output valid, status, found_position, data, fill_count, last,
                  input ready);
  modport sink   (input valid, status, found_position, data, fill_count, last,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/iaids_cell.sv =====
// One storage cell of the array chain: holds a single entry and shifts it
// toward either neighbor or rotates it in from the head. Depends on iaids_pkg.
`default_nettype none

module iaids_cell #(
  parameter int IDX        = 0,
  parameter int DATA_WIDTH = 32,
  parameter int PW         = 5
) (
  input  wire logic                         clk,
  input  wire iaids_pkg::cell_op_t          op,
  input  wire logic [PW-1:0]                pos,
  input  wire logic [PW-1:0]                cnt,
  input  wire logic signed [DATA_WIDTH-1:0] value,
  input  wire logic signed [DATA_WIDTH-1:0] left_d,
  input  wire logic signed [DATA_WIDTH-1:0] right_d,
  input  wire logic signed [DATA_WIDTH-1:0] head_d,
  output logic signed [DATA_WIDTH-1:0]      entry_q
);

  localparam logic [PW-1:0] IDX_V = PW'(IDX);
  localparam logic [PW-1:0] IDX_N = PW'(IDX + 1);

  logic signed [DATA_WIDTH-1:0] entry_r;
  logic signed [DATA_WIDTH-1:0] entry_nxt;

  // Pick the next entry from the broadcast operation and this cell's place
  always_comb begin
    entry_nxt = entry_r;
    case (op)
      iaids_pkg::OP_INSERT: begin
        if (IDX_V > pos) begin
          entry_nxt = left_d;
        end else if (IDX_V == pos) begin
          entry_nxt = value;
        end
      end
      iaids_pkg::OP_DELETE: begin
        if (IDX_V >= pos) begin
          entry_nxt = right_d;
        end
      end
      iaids_pkg::OP_ROTATE: begin
        if (IDX_N == cnt) begin
          entry_nxt = head_d;
        end else if (IDX_N < cnt) begin
          entry_nxt = right_d;
        end
      end
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_q = entry_r;

endmodule

`default_nettype wire

// ===== rtl/indexed_array_insert_delete_search.sv =====
// Indexed array store on a chain of cells. Insert and delete: result valid the cycle
// after acceptance, so one command per cycle while the sink is ready.
// Search: result valid after one full rotation of the entries past cell 0.
// Display: one result per entry, count in all, one per cycle while the sink is ready.
// Empty search and display answer with STS_EMPTY without rotating. Reset (rst_n low, synchronous)
// empties the store; entry contents are not cleared.
`default_nettype none

`include "assert_macros.svh"

module indexed_array_insert_delete_search #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  iaids_in_if.sink    in_if,
  iaids_out_if.source out_if
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > iaids_pkg::POS_W) ? CW : iaids_pkg::POS_W;

  // Control state
  iaids_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic              found_r, found_nxt;
  logic [CW-1:0]     fpos_r, fpos_nxt;
  logic signed [DATA_WIDTH-1:0] key_r, key_nxt;

  // Output register
  logic                              out_valid_r;
  iaids_pkg::status_t                out_status_r, out_status_nxt;
  logic [CW-1:0]                     out_fpos_r, out_fpos_nxt;
  logic signed [DATA_WIDTH-1:0]      out_data_r, out_data_nxt;
  logic [CW-1:0]                     out_fill_r;
  logic                              out_last_r, out_last_nxt;
  logic                              out_load;

  iaids_pkg::cell_op_t          cell_op;
  logic signed [DATA_WIDTH-1:0] in_val;
  logic signed [DATA_WIDTH-1:0] entry_w [CAPACITY];
  logic signed [DATA_WIDTH-1:0] head;
  logic [PW-1:0]                pos_ext;
  logic [PW-1:0]                cnt_ext;
  logic [CW-1:0]                cnt_m1;
  logic                         accept;
  logic                         out_free;
  logic                         match;
  logic                         last_step;
  logic                         search_end;
  logic                         insert_acc;

  assign in_val   = DATA_WIDTH'(in_if.value);
  assign head     = entry_w[0];
  assign pos_ext  = PW'(in_if.position);
  assign cnt_ext  = PW'(count_r);
  assign cnt_m1   = count_r - CW'(1);
  assign out_free = !out_valid_r || out_if.ready;
  assign in_if.ready = (state_r == iaids_pkg::ST_IDLE) && out_free;
  assign accept   = in_if.valid && in_if.ready;
  assign match    = (head == key_r);
  assign last_step = (idx_r == cnt_m1);
  assign search_end = (state_r == iaids_pkg::ST_SEARCH) && last_step;
  assign insert_acc = accept && (cell_op == iaids_pkg::OP_INSERT);

  // Chain of storage cells; cell 0 is the head that search and display read
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DATA_WIDTH-1:0] left_d;
    logic signed [DATA_WIDTH-1:0] right_d;
    if (g == 0) begin : g_first
      assign left_d = in_val;
    end else begin : g_mid_l
      assign left_d = entry_w[g-1];
    end
    if (g == CAPACITY - 1) begin : g_end
      assign right_d = entry_w[g];
    end else begin : g_mid_r
      assign right_d = entry_w[g+1];
    end
    iaids_cell #(
      .IDX        (g),
      .DATA_WIDTH (DATA_WIDTH),
      .PW         (PW)
    ) u_cell (
      .clk     (clk),
      .op      (cell_op),
      .pos     (pos_ext),
      .cnt     (cnt_ext),
      .value   (in_val),
      .left_d  (left_d),
      .right_d (right_d),
      .head_d  (head),
      .entry_q (entry_w[g])
    );
  end

  // Next state, cell operation and result assembly
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    found_nxt      = found_r;
    fpos_nxt       = fpos_r;
    key_nxt        = key_r;
    cell_op        = iaids_pkg::OP_HOLD;
    out_load       = 1'b0;
    out_status_nxt = iaids_pkg::STS_OK;
    out_fpos_nxt   = '0;
    out_data_nxt   = '0;
    out_last_nxt   = 1'b1;
    case (state_r)
      iaids_pkg::ST_IDLE: begin
        if (accept) begin
          case (iaids_pkg::cmd_t'(in_if.command))
            iaids_pkg::CMD_INSERT: begin
              out_load = 1'b1;
              if (count_r == CW'(CAPACITY)) begin
                out_status_nxt = iaids_pkg::STS_FULL;
              end else if (pos_ext > cnt_ext) begin
                out_status_nxt = iaids_pkg::STS_BADPOS;
              end else begin
                cell_op   = iaids_pkg::OP_INSERT;
                count_nxt = count_r + CW'(1);
              end
            end
            iaids_pkg::CMD_DELETE: begin
              out_load = 1'b1;
              if (count_r == '0) begin
                out_status_nxt = iaids_pkg::STS_EMPTY;
              end else if (pos_ext >= cnt_ext) begin
                out_status_nxt = iaids_pkg::STS_BADPOS;
              end else begin
                cell_op   = iaids_pkg::OP_DELETE;
                count_nxt = cnt_m1;
              end
            end
            iaids_pkg::CMD_SEARCH: begin
              if (count_r == '0) begin
                out_load       = 1'b1;
                out_status_nxt = iaids_pkg::STS_EMPTY;
              end else begin
                key_nxt   = in_val;
                idx_nxt   = '0;
                found_nxt = 1'b0;
                fpos_nxt  = '0;
                state_nxt = iaids_pkg::ST_SEARCH;
              end
            end
            iaids_pkg::CMD_DISPLAY: begin
              if (count_r == '0) begin
                out_load       = 1'b1;
                out_status_nxt = iaids_pkg::STS_EMPTY;
              end else begin
                idx_nxt   = '0;
                state_nxt = iaids_pkg::ST_DISPLAY;
              end
            end
            default: out_load = 1'b0;
          endcase
        end
      end
      iaids_pkg::ST_SEARCH: begin
        // Rotate one full turn, comparing each entry as it reaches the head
        cell_op = iaids_pkg::OP_ROTATE;
        if (match && !found_r) begin
          found_nxt = 1'b1;
          fpos_nxt  = idx_r;
        end
        if (last_step) begin
          out_load  = 1'b1;
          state_nxt = iaids_pkg::ST_IDLE;
          if (found_r || match) begin
            out_status_nxt = iaids_pkg::STS_OK;
            out_fpos_nxt   = found_r ? fpos_r : idx_r;
          end else begin
            out_status_nxt = iaids_pkg::STS_NOTFOUND;
          end
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      iaids_pkg::ST_DISPLAY: begin
        // Emit the head and rotate; hold while the result register is full
        if (out_free) begin
          cell_op      = iaids_pkg::OP_ROTATE;
          out_load     = 1'b1;
          out_data_nxt = head;
          out_last_nxt = last_step;
          if (last_step) begin
            state_nxt = iaids_pkg::ST_IDLE;
          end else begin
            idx_nxt = idx_r + CW'(1);
          end
        end
      end
      default: state_nxt = iaids_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= iaids_pkg::ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      found_r <= found_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    fpos_r <= fpos_nxt;
    key_r  <= key_nxt;
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_fpos_r   <= out_fpos_nxt;
      out_data_r   <= out_data_nxt;
      out_fill_r   <= count_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.status         = out_status_r;
  assign out_if.found_position = iaids_pkg::FPOS_W'(out_fpos_r);
  assign out_if.data           = iaids_pkg::VALUE_W'(out_data_r);
  assign out_if.fill_count     = iaids_pkg::FILL_W'(out_fill_r);
  assign out_if.last           = out_last_r;

  // Checks
  `IAIDS_ASSERT_IMP(a_count_max, clk, rst_n, 1'b1, count_r <= CW'(CAPACITY))
  `IAIDS_ASSERT_IMP(a_ready_idle, clk, rst_n, in_if.ready, state_r == iaids_pkg::ST_IDLE)
  `IAIDS_ASSERT_IMP(a_search_slot, clk, rst_n, search_end, !out_valid_r)
  `IAIDS_ASSERT_NXT(a_insert_grows, clk, rst_n, insert_acc, count_r == $past(count_r) + CW'(1))

endmodule

`default_nettype wire
